FILE: hdl/top_k_farthest_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// top_k_farthest_tracker_core macros
// Assertion macros shared by the tracker RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef TOP_K_FARTHEST_TRACKER_CORE_MACROS_SVH
`define TOP_K_FARTHEST_TRACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge out of reset
`define TKFT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tracker assertion failed");

// consequent holds in the cycle after the antecedent
`define TKFT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`else

`define TKFT_ASSERT(name, clk, rst_n, prop)
`define TKFT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/tkft_pkg.sv
// ----------------------------------------------------------------------------
// tkft_pkg
// Types, constants and the ranking function of the top-k farthest tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tkft_pkg;

    localparam int ID_W       = 31;
    localparam int DIST_W     = 32;
    localparam int KEEP_W     = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // register select (word index bit of paddr)
    localparam logic REG_KEEP_COUNT = 1'b0;

    // keep_count after reset
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   obj_id;
        logic [DIST_W-1:0] obj_dist;
    } req_t;

    typedef struct packed {
        logic              prune_valid;
        logic [DIST_W-1:0] prune_dist;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_id;
        logic [DIST_W-1:0] entry_dist;
        logic              last;
    } rsp_t;

    // broadcast of an insert to every cell
    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } ins_t;

    // neighbor link: a cell's contents and whether the new pair outranks it
    typedef struct packed {
        logic              shift;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } link_t;

    // a ranks ahead of b: larger distance, then larger id
    function automatic logic ranks_before(
        input logic [ID_W-1:0]   id_a,
        input logic [DIST_W-1:0] dist_a,
        input logic [ID_W-1:0]   id_b,
        input logic [DIST_W-1:0] dist_b
    );
        logic result;
        if (dist_a != dist_b)
        begin
            result = (dist_a > dist_b);
        end
        else
        begin
            result = (id_a > id_b);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tkft_cell.sv
// ----------------------------------------------------------------------------
// tkft_cell
// One compare-and-shift slot of the sorted list: keeps its pair, takes the
// new pair, or takes its upper neighbor's pair on an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module tkft_cell (
    input  wire logic            clk,
    input  wire tkft_pkg::ins_t  ins,
    input  wire logic            slot_valid,
    input  wire tkft_pkg::link_t prev,
    output tkft_pkg::link_t      link
);
    import tkft_pkg::*;

    logic [ID_W-1:0]   id_reg,   id_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              outranked;

    // empty slots always yield to the new pair
    assign outranked = !slot_valid || ranks_before(ins.id, ins.distance, id_reg, dist_reg);

    // shift down when the insert point lies above, load at the insert point
    always_comb
    begin
        id_next   = id_reg;
        dist_next = dist_reg;
        if (ins.en)
        begin
            if (prev.shift)
            begin
                id_next   = prev.id;
                dist_next = prev.distance;
            end
            else if (outranked)
            begin
                id_next   = ins.id;
                dist_next = ins.distance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        dist_reg <= dist_next;
    end

    assign link.shift    = outranked;
    assign link.id       = id_reg;
    assign link.distance = dist_reg;

endmodule

`default_nettype wire

FILE: hdl/top_k_farthest_tracker_core.sv
// ----------------------------------------------------------------------------
// top_k_farthest_tracker_core
// Insert: the cell row updates at the transfer; the prune result is
//   registered from ST_PRUNE once the result slot is free. No command is
//   taken before that. Read: one entry per cycle from the output register
//   while the receiver is ready; an empty list gives one last-only result.
// Reset: list empty, keep_count = 1; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_k_farthest_tracker_core_macros.svh"

module top_k_farthest_tracker_core #(
    parameter int MAX_KEEP = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tkft_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tkft_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tkft_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // commands
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire tkft_pkg::req_t                    req,
    // results
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output tkft_pkg::rsp_t                         rsp
);
    import tkft_pkg::*;

    localparam int CW = $clog2(MAX_KEEP + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_PRUNE, ST_READ} state_t;

    state_t            state_reg,     state_next;
    logic [KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic [CW-1:0]     count_reg,     count_next;
    logic [CW-1:0]     read_idx_reg,  read_idx_next;
    logic              prune_hit_reg, prune_hit_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg,       rsp_next;

    logic              req_fire;
    logic              slot_free;
    logic              cfg_write;
    logic [CW-1:0]     eff_k;
    logic [CW:0]       n_plus;
    logic              hit;
    logic [CW-1:0]     sel;
    ins_t              ins;
    link_t             links [MAX_KEEP+1];
    logic [MAX_KEEP-1:0] slot_valid;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_KEEP_COUNT)
                     ? {{(APB_DATA_W-KEEP_W){1'b0}}, keep_count_reg} : '0;

    // effective k: zero acts as one, above the cell count acts as the cell count
    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            eff_k = CW'(1);
        end
        else if (32'(keep_count_reg) > MAX_KEEP)
        begin
            eff_k = CW'(MAX_KEEP);
        end
        else
        begin
            eff_k = CW'(keep_count_reg);
        end
    end

    // handshake
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // insert broadcast and count update
    assign ins.en       = req_fire && (req.cmd == CMD_INSERT);
    assign ins.id       = req.obj_id;
    assign ins.distance = req.obj_dist;
    assign n_plus       = {1'b0, count_reg} + (CW+1)'(1);
    assign hit          = (n_plus > {1'b0, eff_k});

    // cell row
    assign links[0] = '{shift: 1'b0, id: '0, distance: '0};

    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        assign slot_valid[i] = (CW'(i) < count_reg);

        tkft_cell u_cell (
            .clk        (clk),
            .ins        (ins),
            .slot_valid (slot_valid[i]),
            .prev       (links[i]),
            .link       (links[i+1])
        );
    end

    // single read port on the row: k-th entry for prune, cursor for read out
    // (link i + 1 carries cell i)
    assign sel = (state_reg == ST_PRUNE) ? eff_k : (read_idx_reg + CW'(1));

    // control and result register
    always_comb
    begin
        state_next      = state_reg;
        keep_count_next = keep_count_reg;
        count_next      = count_reg;
        read_idx_next   = read_idx_reg;
        prune_hit_next  = prune_hit_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;

        if (cfg_write && (paddr[2] == REG_KEEP_COUNT))
        begin
            keep_count_next = pwdata[KEEP_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == CMD_INSERT)
                    begin
                        prune_hit_next = hit;
                        count_next     = hit ? eff_k : n_plus[CW-1:0];
                        state_next     = ST_PRUNE;
                    end
                    else
                    begin
                        read_idx_next = '0;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_PRUNE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.prune_valid = prune_hit_reg;
                    rsp_next.prune_dist  = prune_hit_reg ? links[sel].distance : '0;
                    rsp_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (count_reg == '0)
                    begin
                        rsp_next.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        rsp_next.entry_valid = 1'b1;
                        rsp_next.entry_id    = links[sel].id;
                        rsp_next.entry_dist  = links[sel].distance;
                        rsp_next.last        = (read_idx_reg + CW'(1) == count_reg);
                        read_idx_next        = read_idx_reg + CW'(1);
                        if (read_idx_reg + CW'(1) == count_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keep_count_reg <= KEEP_RESET;
            count_reg      <= '0;
            read_idx_reg   <= '0;
            prune_hit_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            keep_count_reg <= keep_count_next;
            count_reg      <= count_next;
            read_idx_reg   <= read_idx_next;
            prune_hit_reg  <= prune_hit_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    // checks
    `TKFT_ASSERT(a_count_bound, clk, rst_n, 32'(count_reg) <= MAX_KEEP)
    `TKFT_ASSERT_NEXT(a_insert_fills, clk, rst_n, ins.en,
                      (count_reg != '0) && (state_reg == ST_PRUNE))
    `TKFT_ASSERT(a_rsp_kind, clk, rst_n, !(rsp_valid_reg && rsp_reg.entry_valid && rsp_reg.prune_valid))

    // kept entries stay in ranked order
    for (genvar j = 0; j + 1 < MAX_KEEP; j++)
    begin : g_sorted
        `TKFT_ASSERT(a_sorted, clk, rst_n,
                     !slot_valid[j+1] || !ranks_before(links[j+2].id, links[j+2].distance,
                                                       links[j+1].id, links[j+1].distance))
    end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// top_k_farthest_tracker_core testbench
// Drives insert and read commands into the tracker and checks every result
// transfer against an in-bench model of the sorted top-k list. Directed
// cases cover the empty list, ties, equal pairs, truncation and keep_count
// limits. Random traffic follows under three idling mixes and several
// keep_count settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tkft_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam logic [APB_ADDR_W-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};

    // DUT connections, all inputs known from time zero
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // idling mix, percent of cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // list model
    logic [ID_W-1:0]   list_id   [LIST_DEPTH+1];
    logic [DIST_W-1:0] list_dist [LIST_DEPTH+1];
    int                list_len  = 0;
    logic [KEEP_W-1:0] keep_reg  = KEEP_RESET;
    rsp_t              pending_rsps[$];

    // bookkeeping
    int fail_count    = 0;
    int insert_count  = 0;
    int read_count    = 0;
    int checked_count = 0;
    int keep_writes   = 0;

    top_k_farthest_tracker_core #(
        .MAX_KEEP (LIST_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("top_k_farthest_tracker_core regression: fail");
        $finish;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // append one expected result to the scoreboard queue
    function automatic void expect_result(input rsp_t r);
        pending_rsps = {pending_rsps, r};
    endfunction

    // update the list model for one accepted command and queue its results
    function automatic void predict_results(input req_t item);
        rsp_t r;
        int   n;
        int   pos;
        int   k;
        int   i;
        n = list_len;
        r = '0;
        if (item.cmd == CMD_READ)
        begin
            read_count++;
            if (n == 0)
            begin
                r.last = 1'b1;
                expect_result(r);
            end
            for (i = 0; i < n; i++)
            begin
                r = '0;
                r.entry_valid = 1'b1;
                r.entry_id    = list_id[i];
                r.entry_dist  = list_dist[i];
                r.last        = (i == n - 1);
                expect_result(r);
            end
        end
        else
        begin
            insert_count++;
            // first kept entry that the new pair outranks
            pos = n;
            for (i = 0; i < n; i++)
            begin
                if ((item.obj_dist != list_dist[i]) ? (item.obj_dist > list_dist[i])
                                                    : (item.obj_id > list_id[i]))
                begin
                    pos = i;
                    break;
                end
            end
            for (i = n; i > pos; i--)
            begin
                list_id[i]   = list_id[i-1];
                list_dist[i] = list_dist[i-1];
            end
            list_id[pos]   = item.obj_id;
            list_dist[pos] = item.obj_dist;
            // zero acts as one, anything above the depth as the depth
            k = (keep_reg == 0) ? 1 : ((keep_reg > LIST_DEPTH) ? LIST_DEPTH : int'(keep_reg));
            if (n + 1 > k)
            begin
                r.prune_valid = 1'b1;
                r.prune_dist  = list_dist[k-1];
                list_len      = k;
            end
            else
            begin
                list_len = n + 1;
            end
            r.last = 1'b1;
            expect_result(r);
        end
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("result transfer with no expected result: %p", rsp);
                fail_count++;
            end
            else
            begin
                rsp_t want;
                want = pending_rsps.pop_front();
                checked_count++;
                compare_field("prune_valid", 64'(want.prune_valid), 64'(rsp.prune_valid));
                compare_field("prune_dist",  64'(want.prune_dist),  64'(rsp.prune_dist));
                compare_field("entry_valid", 64'(want.entry_valid), 64'(rsp.entry_valid));
                compare_field("entry_id",    64'(want.entry_id),    64'(rsp.entry_id));
                compare_field("entry_dist",  64'(want.entry_dist),  64'(rsp.entry_dist));
                compare_field("last",        64'(want.last),        64'(rsp.last));
            end
        end
    end

    // one command transfer; valid stays high into the next call unless it idles
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [DIST_W-1:0] distance);
        req_t item;
        item.cmd      = cmd;
        item.obj_id   = id;
        item.obj_dist = distance;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predict_results(item);
    endtask

    // hold off the sender until every expected result is in
    task automatic wait_for_drain();
        if (pending_rsps.size() != 0)
        begin
            req_valid <= 1'b0;
            while (pending_rsps.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // write keep_count, then read it back
    task automatic write_keep_count(input logic [KEEP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEEP_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        keep_reg = value;
        keep_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== APB_DATA_W'(value))
        begin
            $error("keep_count readback mismatch: expected %0h, actual %0h", value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // k = 1 from reset: empty read, invalid then valid prune, extremes
    task automatic test_empty_and_single();
        send_item(CMD_READ, ID_MAX, DIST_MAX);
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, ID_MAX, DIST_MAX);
        send_item(CMD_INSERT, ID_MAX, '0);
        send_item(CMD_READ, '0, '0);
        wait_for_drain();
    endtask

    // ties on distance, an equal pair, and a pair that falls off the end
    task automatic test_ties_and_truncation();
        write_keep_count(5'd4);
        send_item(CMD_INSERT, 31'd5, 32'h0001_8000);
        send_item(CMD_INSERT, 31'd9, 32'h0001_8000);
        send_item(CMD_INSERT, 31'd5, 32'h0001_8000);
        send_item(CMD_INSERT, 31'd7, 32'h0001_8000);
        send_item(CMD_READ, 31'h2AAA_AAAA, 32'h5555_5555);
        send_item(CMD_INSERT, 31'd1, 32'h0000_0000);
        send_item(CMD_INSERT, 31'd8, 32'h0001_8000);
        send_item(CMD_READ, 31'h5555_5555, 32'hAAAA_AAAA);
        wait_for_drain();
    endtask

    // keep_count of zero, above the depth, and lowered below the list length
    task automatic test_keep_count_limits();
        int i;
        write_keep_count(5'd0);
        send_item(CMD_INSERT, 31'd3, 32'h0000_0001);
        send_item(CMD_READ, '0, '0);
        wait_for_drain();
        write_keep_count(5'd31);
        for (i = 0; i < 4; i++)
        begin
            send_item(CMD_INSERT, ID_W'($urandom), $urandom);
        end
        send_item(CMD_READ, '0, '0);
        wait_for_drain();
        write_keep_count(5'd17);
        send_item(CMD_INSERT, 31'd0, DIST_MAX);
        send_item(CMD_READ, '0, '0);
        wait_for_drain();
        write_keep_count(5'd2);
        send_item(CMD_READ, '0, '0);
        send_item(CMD_INSERT, 31'd0, 32'h0000_0000);
        send_item(CMD_READ, '0, '0);
        wait_for_drain();
    endtask

    // random traffic in segments, keep_count changed between segments
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int segments);
        static logic [KEEP_W-1:0] keep_plan [9] = '{5'd16, 5'd1, 5'd7, 5'd17, 5'd2,
                                                   5'd0, 5'd12, 5'd31, 5'd5};
        static int                plan_idx = 0;
        int                       seg;
        int                       n;
        logic                     cmd;
        logic [ID_W-1:0]          id;
        logic [DIST_W-1:0]        distance;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (seg = 0; seg < segments; seg++)
        begin
            wait_for_drain();
            write_keep_count(keep_plan[plan_idx % 9]);
            plan_idx++;
            for (n = 0; n < 50; n++)
            begin
                cmd = ($urandom_range(4) == 0) ? CMD_READ : CMD_INSERT;
                // small ids and a small distance pool make ties common
                id  = ($urandom_range(1) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
                case ($urandom_range(9))
                    0, 1, 2, 3: distance = DIST_W'($urandom_range(15));
                    4:
                    begin
                        case ($urandom_range(3))
                            0:       distance = '0;
                            1:       distance = DIST_MAX;
                            2:       distance = 32'hFFFF_0000;
                            default: distance = 32'h0001_0000;
                        endcase
                    end
                    default: distance = $urandom;
                endcase
                send_item(cmd, id, distance);
                if (seg == 0 && n == 25)
                begin
                    wait_for_drain();
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_single();
        test_ties_and_truncation();
        test_keep_count_limits();
        test_random_traffic(30, 57, 3);
        test_random_traffic(57, 30, 3);
        test_random_traffic(0, 0, 3);

        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("covered %0d inserts and %0d reads under %0d keep_count writes",
                 insert_count, read_count, keep_writes);
        $display("%0d result transfers checked", checked_count);
        if (fail_count == 0 && pending_rsps.size() == 0)
        begin
            $display("top_k_farthest_tracker_core regression: pass");
        end
        else
        begin
            $display("top_k_farthest_tracker_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
